[hw/rtl/wws_pkg.sv]
// Package with shared types, constants and CORDIC angle table for the weather window statistics.
`timescale 1ns / 1ps
`default_nettype none
package wws_pkg;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned DIV_STEPS    = 32;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_WINDOW_SECONDS = 1'b0;
    localparam logic [0:0] REG_DECLINATION    = 1'b1;

    localparam logic [11:0] WINDOW_RESET      = 12'd60;
    localparam logic [15:0] DECLINATION_RESET = 16'd2875;
    localparam logic [15:0] FULL_CIRCLE       = 16'd36000;
    localparam logic [15:0] HALF_CIRCLE       = 16'd18000;
    localparam logic [15:0] QUARTER_CIRCLE    = 16'd9000;
    localparam logic [15:0] COUNT_FULL        = 16'hFFFF;

    // Channel positions inside a valid mask.
    localparam int unsigned CH_SPD = 0;
    localparam int unsigned CH_DIR = 1;
    localparam int unsigned CH_TMP = 2;
    localparam int unsigned CH_HUM = 3;
    localparam int unsigned CH_PRS = 4;

    typedef struct packed {
        logic [0:0]  station;
        logic [31:0] time_sec;
        logic [19:0] time_usec;
        logic [4:0]  valid_mask;
        logic [15:0] speed;
        logic [15:0] direction;
        logic signed [11:0] temperature;
        logic [9:0]  humidity;
        logic [13:0] pressure;
    } t_sample;

    typedef struct packed {
        logic [0:0]  out_station;
        logic [31:0] window_end_sec;
        logic [4:0]  stats_valid_mask;
        logic [15:0] mean_speed;
        logic [15:0] min_speed;
        logic [15:0] max_speed;
        logic [15:0] mean_dir_magnetic;
        logic [15:0] mean_dir_true;
        logic signed [11:0] mean_temperature;
        logic [9:0]  mean_humidity;
        logic [13:0] mean_pressure;
    } t_result;

    typedef struct packed {
        logic [0:0]  cfg_index;
        logic [15:0] cfg_data;
    } t_cfg;

    // Arctangent of 2^-i in units of 1/25600 degree.
    function automatic logic signed [23:0] atan_entry(input logic [3:0] idx);
        case (idx)
            4'd0:  atan_entry = 24'sd1152000;
            4'd1:  atan_entry = 24'sd680065;
            4'd2:  atan_entry = 24'sd359328;
            4'd3:  atan_entry = 24'sd182400;
            4'd4:  atan_entry = 24'sd91554;
            4'd5:  atan_entry = 24'sd45822;
            4'd6:  atan_entry = 24'sd22916;
            4'd7:  atan_entry = 24'sd11459;
            4'd8:  atan_entry = 24'sd5730;
            4'd9:  atan_entry = 24'sd2865;
            4'd10: atan_entry = 24'sd1432;
            4'd11: atan_entry = 24'sd716;
            4'd12: atan_entry = 24'sd358;
            4'd13: atan_entry = 24'sd179;
            4'd14: atan_entry = 24'sd90;
            default: atan_entry = 24'sd45;
        endcase
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_WIN,
        ST_DECIDE,
        ST_EMIT_DIV,
        ST_EMIT_VEC,
        ST_EMIT_ROUND,
        ST_EMIT_WRAP,
        ST_EMIT_OUT,
        ST_NEW_WIN,
        ST_NEW_END,
        ST_ROT,
        ST_ACCUM
    } t_state;

endpackage
`default_nettype wire

[hw/rtl/wws_if.sv]
// Valid/ready channel interfaces for samples, results and configuration words.
`timescale 1ns / 1ps
`default_nettype none
interface wws_sample_if;
    import wws_pkg::*;
    logic    valid;
    logic    ready;
    t_sample data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wws_result_if;
    import wws_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wws_cfg_if;
    import wws_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/wws_front.sv]
// Front end: takes sample words, drops out-of-range stations and queues the rest.
`timescale 1ns / 1ps
`default_nettype none
module wws_front
    import wws_pkg::*;
#(
    parameter int unsigned NUM_STATIONS = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wws_sample_if.sink   s_in,
    output logic         o_q_valid,
    output t_sample      o_q_data,
    input  wire logic    i_q_pop
);
    localparam int unsigned DEPTH = 2;

    t_sample      r_mem [DEPTH];
    logic [0:0]   r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count;
    logic         w_push, w_keep;

    // A station beyond the configured count is consumed and dropped.
    assign w_keep    = ({31'd0, s_in.data.station} < NUM_STATIONS);
    assign s_in.ready = (r_count != 2'(DEPTH));
    assign w_push    = s_in.valid && s_in.ready && w_keep;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_data  = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= s_in.data;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

[hw/rtl/wws_back.sv]
// Back end: window tracking, accumulation and CORDIC for each sample, with serial division.
`timescale 1ns / 1ps
`default_nettype none
module wws_back
    import wws_pkg::*;
#(
    parameter int unsigned NUM_STATIONS = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  t_sample      i_q_data,
    output logic         o_q_pop,
    input  wire logic [11:0] i_window_seconds,
    input  wire logic [15:0] i_declination,
    output logic         o_busy,
    wws_result_if.source m_out
);
    localparam int unsigned SW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

    // Per-station state.
    logic [31:0]        r_wend  [NUM_STATIONS];
    logic [15:0]        r_cnt   [NUM_STATIONS][5];
    logic [31:0]        r_ssum  [NUM_STATIONS];
    logic signed [31:0] r_tsum  [NUM_STATIONS];
    logic [31:0]        r_hsum  [NUM_STATIONS];
    logic [31:0]        r_psum  [NUM_STATIONS];
    logic signed [31:0] r_sinsum[NUM_STATIONS];
    logic signed [31:0] r_cossum[NUM_STATIONS];
    logic [15:0]        r_smin  [NUM_STATIONS];
    logic [15:0]        r_smax  [NUM_STATIONS];

    t_state r_state, n_state;
    t_sample r_smp;
    logic [SW-1:0] r_st;
    logic [4:0] r_sub;
    logic [5:0] r_step;

    // Shared serial divider: 32-bit dividend, 17-bit divisor (up to 65535 or window).
    logic [31:0] r_quo;
    logic [32:0] r_rem;
    logic [16:0] r_den;
    logic [32:0] w_trial;

    // CORDIC working registers.
    logic signed [35:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic               r_flip;

    // Result being built.
    t_result r_res;
    logic    r_out_valid;
    logic [16:0] w_dir_mod;
    logic [16:0] w_dec_mod;
    logic signed [16:0] w_ang;
    logic [32:0] w_end_prod;
    logic signed [26:0] w_zr;
    logic [17:0] w_tru;

    // Window end of the station in hand.
    logic [31:0] w_wend;
    assign w_wend = r_wend[r_st];

    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_res;
    assign o_busy      = (r_state != ST_IDLE) || r_out_valid || i_q_valid;
    assign w_trial     = {r_rem[31:0], r_quo[31]} - {16'd0, r_den};

    // Direction folded into one range, declination likewise.
    assign w_dir_mod = (r_smp.direction >= FULL_CIRCLE) ?
                       {1'b0, r_smp.direction - FULL_CIRCLE} : {1'b0, r_smp.direction};
    assign w_dec_mod = (i_declination >= FULL_CIRCLE) ?
                       {1'b0, i_declination - FULL_CIRCLE} : {1'b0, i_declination};
    assign w_end_prod = ({1'b0, r_quo} + 33'd1) * 33'({21'd0, r_den[11:0]});
    assign w_zr = ($signed({r_z[25], r_z}) + 27'sd128) >>> 8;
    assign w_tru = {2'b0, r_res.mean_dir_magnetic} + {1'b0, w_dec_mod};

    assign o_q_pop = (r_state == ST_ACCUM);

    logic w_pass;
    assign w_pass = (r_smp.time_sec > w_wend) ||
                    ((r_smp.time_sec == w_wend) && (r_smp.time_usec != 20'd0));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. A freshly opened first window is checked again against the sample.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_q_valid && !r_out_valid) n_state = ST_DECIDE;
            ST_DECIDE:     n_state = (w_wend == 32'd0) ? ST_NEW_WIN :
                                     (w_pass ? ST_EMIT_DIV : ST_ROT);
            ST_EMIT_DIV:   if (r_step == 6'(DIV_STEPS) && r_sub == 5'd4) n_state = ST_EMIT_VEC;
            ST_EMIT_VEC:   if (r_step == 6'(CORDIC_STEPS)) n_state = ST_EMIT_ROUND;
            ST_EMIT_ROUND: n_state = ST_EMIT_WRAP;
            ST_EMIT_WRAP:  n_state = ST_EMIT_OUT;
            ST_EMIT_OUT:   n_state = ST_NEW_WIN;
            ST_NEW_WIN:    n_state = ST_DIV_WIN;
            ST_DIV_WIN:    if (r_step == 6'(DIV_STEPS)) n_state = ST_NEW_END;
            ST_NEW_END:    n_state = (r_sub == 5'd0) ? ST_DECIDE : ST_ROT;
            ST_ROT:        if (r_step == 6'(CORDIC_STEPS)) n_state = ST_ACCUM;
            ST_ACCUM:      n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_STATIONS; s++) begin
                r_wend[s] <= '0;
                for (int c = 0; c < 5; c++) r_cnt[s][c] <= '0;
                r_ssum[s] <= '0; r_tsum[s] <= '0; r_hsum[s] <= '0; r_psum[s] <= '0;
                r_sinsum[s] <= '0; r_cossum[s] <= '0; r_smin[s] <= '0; r_smax[s] <= '0;
            end
            r_step <= '0;
            r_sub  <= '0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_smp  <= i_q_data;
                    r_st   <= SW'(i_q_data.station);
                    r_step <= '0;
                    r_sub  <= '0;
                end
                ST_DECIDE: begin
                    r_step <= '0;
                    r_sub  <= '0;
                    r_rem  <= '0;
                    r_quo  <= r_ssum[r_st];
                    r_den  <= {1'b0, r_cnt[r_st][CH_SPD]};
                    r_res  <= '0;
                end
                ST_EMIT_DIV: begin
                    // One quotient bit a cycle for each of the four means.
                    if (r_step != 6'(DIV_STEPS)) begin
                        if (!w_trial[32]) begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[31:0], r_quo[31]};
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_step <= r_step + 6'd1;
                    end else begin
                        r_step <= '0;
                        r_rem  <= '0;
                        case (r_sub)
                            5'd0: begin
                                r_res.mean_speed <= r_quo[15:0];
                                r_quo <= r_tsum[r_st][31] ? 32'(-r_tsum[r_st])
                                                          : 32'(r_tsum[r_st]);
                                r_den <= {1'b0, r_cnt[r_st][CH_TMP]};
                            end
                            5'd1: begin
                                r_res.mean_temperature <= r_tsum[r_st][31] ?
                                    12'(-r_quo) : r_quo[11:0];
                                r_quo <= r_hsum[r_st];
                                r_den <= {1'b0, r_cnt[r_st][CH_HUM]};
                            end
                            5'd2: begin
                                r_res.mean_humidity <= r_quo[9:0];
                                r_quo <= r_psum[r_st];
                                r_den <= {1'b0, r_cnt[r_st][CH_PRS]};
                            end
                            5'd3: begin
                                r_res.mean_pressure <= r_quo[13:0];
                                r_x <= 36'(r_cossum[r_st]);
                                r_y <= 36'(r_sinsum[r_st]);
                                r_z <= '0;
                            end
                            default: begin
                                // Vectoring setup: move into the right half plane.
                                if (r_x < 0) begin
                                    r_x <= -r_x;
                                    r_y <= -r_y;
                                    r_z <= 26'sd4608000;
                                end
                            end
                        endcase
                        if (r_sub != 5'd4) begin
                            r_sub <= r_sub + 5'd1;
                        end
                    end
                end
                ST_EMIT_VEC: begin
                    if (r_step != 6'(CORDIC_STEPS)) begin
                        if (r_y >= 0) begin
                            r_x <= r_x + (r_y >>> r_step[3:0]);
                            r_y <= r_y - (r_x >>> r_step[3:0]);
                            r_z <= r_z + 26'(atan_entry(r_step[3:0]));
                        end else begin
                            r_x <= r_x - (r_y >>> r_step[3:0]);
                            r_y <= r_y + (r_x >>> r_step[3:0]);
                            r_z <= r_z - 26'(atan_entry(r_step[3:0]));
                        end
                        r_step <= r_step + 6'd1;
                    end
                end
                ST_EMIT_ROUND: begin
                    // Round to hundredths; the angle stays within one turn either way.
                    if (w_zr < 0) begin
                        r_res.mean_dir_magnetic <= 16'(w_zr + 27'sd36000);
                    end else if (w_zr >= 27'sd36000) begin
                        r_res.mean_dir_magnetic <= 16'(w_zr - 27'sd36000);
                    end else begin
                        r_res.mean_dir_magnetic <= 16'(w_zr);
                    end
                    if (r_cossum[r_st] == 0 && r_sinsum[r_st] == 0) begin
                        r_res.mean_dir_magnetic <= QUARTER_CIRCLE;
                    end
                end
                ST_EMIT_WRAP: begin
                    r_res.mean_dir_true <= (w_tru >= 18'(FULL_CIRCLE)) ?
                        16'(w_tru - 18'(FULL_CIRCLE)) : w_tru[15:0];
                end
                ST_EMIT_OUT: begin
                    r_res.out_station    <= 1'(r_st);
                    r_res.window_end_sec <= w_wend;
                    for (int c = 0; c < 5; c++) begin
                        r_res.stats_valid_mask[c] <= (r_cnt[r_st][c] != 16'd0);
                    end
                    if (r_cnt[r_st][CH_SPD] != 16'd0) begin
                        r_res.min_speed <= r_smin[r_st];
                        r_res.max_speed <= r_smax[r_st];
                    end else begin
                        r_res.mean_speed <= '0;
                        r_res.min_speed  <= '0;
                        r_res.max_speed  <= '0;
                    end
                    if (r_cnt[r_st][CH_DIR] == 16'd0) begin
                        r_res.mean_dir_magnetic <= '0;
                        r_res.mean_dir_true     <= '0;
                    end
                    if (r_cnt[r_st][CH_TMP] == 16'd0) r_res.mean_temperature <= '0;
                    if (r_cnt[r_st][CH_HUM] == 16'd0) r_res.mean_humidity <= '0;
                    if (r_cnt[r_st][CH_PRS] == 16'd0) r_res.mean_pressure <= '0;
                    r_out_valid <= 1'b1;
                    // Clear the station for the next window.
                    for (int c = 0; c < 5; c++) r_cnt[r_st][c] <= '0;
                    r_ssum[r_st] <= '0; r_tsum[r_st] <= '0;
                    r_hsum[r_st] <= '0; r_psum[r_st] <= '0;
                    r_sinsum[r_st] <= '0; r_cossum[r_st] <= '0;
                    r_smin[r_st] <= '0; r_smax[r_st] <= '0;
                end
                ST_NEW_WIN: begin
                    r_step <= '0;
                    r_rem  <= '0;
                    r_quo  <= r_smp.time_sec;
                    r_den  <= {5'd0, (i_window_seconds == 12'd0) ? 12'd1 : i_window_seconds};
                end
                ST_DIV_WIN: begin
                    if (r_step != 6'(DIV_STEPS)) begin
                        if (!w_trial[32]) begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[31:0], r_quo[31]};
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_step <= r_step + 6'd1;
                    end
                end
                ST_NEW_END: begin
                    r_wend[r_st] <= w_end_prod[32] ? 32'hFFFF_FFFF : w_end_prod[31:0];
                    r_step <= '0;
                    // Rotation setup: reset the start vector and the flip.
                    r_x    <= 36'sd9949;
                    r_y    <= '0;
                    r_flip <= 1'b0;
                end
                ST_ROT: begin
                    if (r_step == 6'd0) begin
                        r_x <= 36'sd9949;
                        r_y <= '0;
                        if (w_ang > $signed({1'b0, QUARTER_CIRCLE})) begin
                            r_z <= 26'((w_ang - $signed({1'b0, HALF_CIRCLE})) * 256);
                            r_flip <= 1'b1;
                        end else if (w_ang < -$signed({1'b0, QUARTER_CIRCLE})) begin
                            r_z <= 26'((w_ang + $signed({1'b0, HALF_CIRCLE})) * 256);
                            r_flip <= 1'b1;
                        end else begin
                            r_z <= 26'(w_ang * 256);
                            r_flip <= 1'b0;
                        end
                        r_step <= 6'd1;
                    end else if (r_step <= 6'(CORDIC_STEPS)) begin
                        if (r_z >= 0) begin
                            r_x <= r_x - (r_y >>> (r_step[3:0] - 4'd1));
                            r_y <= r_y + (r_x >>> (r_step[3:0] - 4'd1));
                            r_z <= r_z - 26'(atan_entry(r_step[3:0] - 4'd1));
                        end else begin
                            r_x <= r_x + (r_y >>> (r_step[3:0] - 4'd1));
                            r_y <= r_y - (r_x >>> (r_step[3:0] - 4'd1));
                            r_z <= r_z + 26'(atan_entry(r_step[3:0] - 4'd1));
                        end
                        r_step <= (r_step == 6'(CORDIC_STEPS)) ? 6'd17 : r_step + 6'd1;
                    end
                end
                ST_ACCUM: begin
                    if (r_smp.valid_mask[CH_SPD] && r_cnt[r_st][CH_SPD] != COUNT_FULL) begin
                        if (r_cnt[r_st][CH_SPD] == 16'd0) begin
                            r_smin[r_st] <= r_smp.speed;
                            r_smax[r_st] <= r_smp.speed;
                        end else begin
                            if (r_smp.speed < r_smin[r_st]) r_smin[r_st] <= r_smp.speed;
                            if (r_smp.speed > r_smax[r_st]) r_smax[r_st] <= r_smp.speed;
                        end
                        r_ssum[r_st] <= r_ssum[r_st] + {16'd0, r_smp.speed};
                        r_cnt[r_st][CH_SPD] <= r_cnt[r_st][CH_SPD] + 16'd1;
                    end
                    if (r_smp.valid_mask[CH_DIR] && r_cnt[r_st][CH_DIR] != COUNT_FULL) begin
                        r_sinsum[r_st] <= r_sinsum[r_st] + (r_flip ? -32'(r_y) : 32'(r_y));
                        r_cossum[r_st] <= r_cossum[r_st] + (r_flip ? -32'(r_x) : 32'(r_x));
                        r_cnt[r_st][CH_DIR] <= r_cnt[r_st][CH_DIR] + 16'd1;
                    end
                    if (r_smp.valid_mask[CH_TMP] && r_cnt[r_st][CH_TMP] != COUNT_FULL) begin
                        r_tsum[r_st] <= r_tsum[r_st] + 32'(r_smp.temperature);
                        r_cnt[r_st][CH_TMP] <= r_cnt[r_st][CH_TMP] + 16'd1;
                    end
                    if (r_smp.valid_mask[CH_HUM] && r_cnt[r_st][CH_HUM] != COUNT_FULL) begin
                        r_hsum[r_st] <= r_hsum[r_st] + {22'd0, r_smp.humidity};
                        r_cnt[r_st][CH_HUM] <= r_cnt[r_st][CH_HUM] + 16'd1;
                    end
                    if (r_smp.valid_mask[CH_PRS] && r_cnt[r_st][CH_PRS] != COUNT_FULL) begin
                        r_psum[r_st] <= r_psum[r_st] + {18'd0, r_smp.pressure};
                        r_cnt[r_st][CH_PRS] <= r_cnt[r_st][CH_PRS] + 16'd1;
                    end
                end
                default: begin
                end
            endcase
            // A known window that the sample does not pass skips the division and goes straight to rotation.
            if (r_state == ST_DECIDE && w_wend != 32'd0 && !w_pass) begin
                r_step <= '0;
            end
        end
    end

    // Signed direction in -17999..18000.
    assign w_ang = (w_dir_mod > {1'b0, HALF_CIRCLE}) ?
                   $signed(w_dir_mod) - $signed({1'b0, FULL_CIRCLE}) : $signed(w_dir_mod);
endmodule
`default_nettype wire

[hw/rtl/weather_window_statistics_top.sv]
// Top level of the weather window statistics block.
// A sample that closes no window goes through the CORDIC rotation and accumulation; the first
// sample of a station takes a window division before that; one that closes a window shows its
// result after the shared bit-serial divider (five passes) and a CORDIC vectoring, then finishes
// after the window-end division and a second CORDIC, the rotation.
// Throughput: one sample at a time in the back end; a two-word queue buffers the input.
// Reset (synchronous, active low) clears all station state and sets the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module weather_window_statistics_top
    import wws_pkg::*;
#(
    parameter int unsigned NUM_STATIONS = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wws_sample_if.sink   s_in,
    wws_cfg_if.sink      s_cfg,
    wws_result_if.source m_out
);
    logic        w_q_valid, w_q_pop, w_busy;
    t_sample     w_q_data;
    logic [11:0] r_window_seconds;
    logic [15:0] r_declination;

    // Configuration registers.
    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_seconds <= WINDOW_RESET;
            r_declination    <= DECLINATION_RESET;
        end else if (s_cfg.valid) begin
            case (s_cfg.data.cfg_index)
                REG_WINDOW_SECONDS: r_window_seconds <= s_cfg.data.cfg_data[11:0];
                REG_DECLINATION:    r_declination    <= s_cfg.data.cfg_data;
                default: begin
                end
            endcase
        end
    end

    wws_front #(.NUM_STATIONS(NUM_STATIONS)) u_front (
        .i_clk, .i_rst_n, .s_in,
        .o_q_valid(w_q_valid), .o_q_data(w_q_data), .i_q_pop(w_q_pop)
    );

    wws_back #(.NUM_STATIONS(NUM_STATIONS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .i_q_data(w_q_data), .o_q_pop(w_q_pop),
        .i_window_seconds(r_window_seconds), .i_declination(r_declination),
        .o_busy(w_busy), .m_out
    );

    // A result word holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result word changed while stalled");
    // Queue pops only with a word present.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from empty queue");
    // A new result rises only while the block is busy.
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_out.valid) |-> w_busy)
        else $error("result without work");
endmodule
`default_nettype wire

[bench/wws_stats_checker.sv]
// Checker that predicts the window statistics and compares every result word.
`timescale 1ns / 1ps
module wws_stats_checker
    import wws_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    wws_sample_if  s_in,
    wws_cfg_if     s_cfg,
    wws_result_if  m_out,
    output int     o_failures,
    output int     o_pending
);

    localparam int NSTA = 2;

    // Arctangent of 2^-i in 1/25600 degree.
    localparam int ARCTAN_STEP [16] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45
    };

    // Predicted state of each station and the two registers.
    logic [11:0] win_len;
    logic [15:0] decl;
    logic [31:0] win_end [NSTA];
    logic [15:0] cnt [NSTA][5];
    longint      spd_sum [NSTA];
    longint      tmp_sum [NSTA];
    longint      hum_sum [NSTA];
    longint      prs_sum [NSTA];
    longint      sin_sum [NSTA];
    longint      cos_sum [NSTA];
    logic [15:0] spd_min [NSTA];
    logic [15:0] spd_max [NSTA];
    t_result     window_stats_q [$];
    int          fail_cnt;

    // Unit vector of a direction by CORDIC rotation.
    function automatic void dir_unit_vector(input logic [15:0] hd,
                                            output longint cx, output longint sy);
        longint a, x, y, z, dx, dy;
        bit flip;
        a = hd % 36000;
        flip = 0;
        x = 9949;
        y = 0;
        if (a > 18000) a -= 36000;
        if (a > 9000) begin
            a -= 18000;
            flip = 1;
        end else if (a < -9000) begin
            a += 18000;
            flip = 1;
        end
        z = a * 256;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN_STEP[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN_STEP[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cx = x;
        sy = y;
    endfunction

    // Mean direction of summed vectors by CORDIC vectoring.
    function automatic logic [15:0] vector_heading(input longint xi, input longint yi);
        longint x, y, z, dx, dy, h;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) return 16'd9000;
        if (x < 0) begin
            x = -x; y = -y; z = 4608000;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARCTAN_STEP[i];
            end else begin
                x -= dx; y += dy; z -= ARCTAN_STEP[i];
            end
        end
        h = ((z + 128) >>> 8) % 36000;
        if (h < 0) h += 36000;
        return h[15:0];
    endfunction

    // Window end after a given time, saturated at 32 bits.
    function automatic logic [31:0] window_close_time(input logic [31:0] t);
        longint w, e;
        w = (win_len == 0) ? 1 : win_len;
        e = (longint'(t) / w + 1) * w;
        return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    function automatic void clear_station(input int s);
        for (int c = 0; c < 5; c++) cnt[s][c] = 0;
        spd_sum[s] = 0; tmp_sum[s] = 0; hum_sum[s] = 0; prs_sum[s] = 0;
        sin_sum[s] = 0; cos_sum[s] = 0; spd_min[s] = 0; spd_max[s] = 0;
    endfunction

    // Statistics of the closing window.
    function automatic t_result window_summary(input int s);
        t_result r;
        logic [15:0] mag;
        longint q;
        r = '0;
        r.out_station = s[0];
        r.window_end_sec = win_end[s];
        if (cnt[s][CH_SPD] != 0) begin
            r.stats_valid_mask[CH_SPD] = 1'b1;
            q = spd_sum[s] / cnt[s][CH_SPD];
            r.mean_speed = q[15:0];
            r.min_speed = spd_min[s];
            r.max_speed = spd_max[s];
        end
        if (cnt[s][CH_DIR] != 0) begin
            r.stats_valid_mask[CH_DIR] = 1'b1;
            mag = vector_heading(cos_sum[s], sin_sum[s]);
            r.mean_dir_magnetic = mag;
            q = (longint'(mag) + decl % 36000) % 36000;
            r.mean_dir_true = q[15:0];
        end
        if (cnt[s][CH_TMP] != 0) begin
            r.stats_valid_mask[CH_TMP] = 1'b1;
            q = tmp_sum[s] / longint'(cnt[s][CH_TMP]);
            r.mean_temperature = q[11:0];
        end
        if (cnt[s][CH_HUM] != 0) begin
            r.stats_valid_mask[CH_HUM] = 1'b1;
            q = hum_sum[s] / cnt[s][CH_HUM];
            r.mean_humidity = q[9:0];
        end
        if (cnt[s][CH_PRS] != 0) begin
            r.stats_valid_mask[CH_PRS] = 1'b1;
            q = prs_sum[s] / cnt[s][CH_PRS];
            r.mean_pressure = q[13:0];
        end
        return r;
    endfunction

    // Close the window if the sample passed it, then accumulate the sample.
    function automatic void absorb_sample(input t_sample d);
        int s;
        longint c, sn;
        s = d.station;
        if (win_end[s] == 0) win_end[s] = window_close_time(d.time_sec);
        if (d.time_sec > win_end[s] || (d.time_sec == win_end[s] && d.time_usec != 0)) begin
            window_stats_q.push_back(window_summary(s));
            clear_station(s);
            win_end[s] = window_close_time(d.time_sec);
        end
        if (d.valid_mask[CH_SPD] && cnt[s][CH_SPD] != COUNT_FULL) begin
            if (cnt[s][CH_SPD] == 0) begin
                spd_min[s] = d.speed;
                spd_max[s] = d.speed;
            end
            if (d.speed < spd_min[s]) spd_min[s] = d.speed;
            if (d.speed > spd_max[s]) spd_max[s] = d.speed;
            spd_sum[s] += d.speed;
            cnt[s][CH_SPD]++;
        end
        if (d.valid_mask[CH_DIR] && cnt[s][CH_DIR] != COUNT_FULL) begin
            dir_unit_vector(d.direction, c, sn);
            sin_sum[s] += sn;
            cos_sum[s] += c;
            cnt[s][CH_DIR]++;
        end
        if (d.valid_mask[CH_TMP] && cnt[s][CH_TMP] != COUNT_FULL) begin
            tmp_sum[s] += longint'(d.temperature);
            cnt[s][CH_TMP]++;
        end
        if (d.valid_mask[CH_HUM] && cnt[s][CH_HUM] != COUNT_FULL) begin
            hum_sum[s] += d.humidity;
            cnt[s][CH_HUM]++;
        end
        if (d.valid_mask[CH_PRS] && cnt[s][CH_PRS] != COUNT_FULL) begin
            prs_sum[s] += d.pressure;
            cnt[s][CH_PRS]++;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_cnt++;
    endtask

    // Compare one result word against the oldest prediction.
    task automatic check_result(input t_result got);
        t_result want;
        if (window_stats_q.size() == 0) begin
            report_mismatch("unexpected result word, station", got.out_station, -1);
            return;
        end
        want = window_stats_q.pop_front();
        if (got.out_station !== want.out_station)
            report_mismatch("out_station", got.out_station, want.out_station);
        if (got.window_end_sec !== want.window_end_sec)
            report_mismatch("window_end_sec", got.window_end_sec, want.window_end_sec);
        if (got.stats_valid_mask !== want.stats_valid_mask)
            report_mismatch("stats_valid_mask", got.stats_valid_mask, want.stats_valid_mask);
        if (got.mean_speed !== want.mean_speed)
            report_mismatch("mean_speed", got.mean_speed, want.mean_speed);
        if (got.min_speed !== want.min_speed)
            report_mismatch("min_speed", got.min_speed, want.min_speed);
        if (got.max_speed !== want.max_speed)
            report_mismatch("max_speed", got.max_speed, want.max_speed);
        if (got.mean_dir_magnetic !== want.mean_dir_magnetic)
            report_mismatch("mean_dir_magnetic", got.mean_dir_magnetic,
                            want.mean_dir_magnetic);
        if (got.mean_dir_true !== want.mean_dir_true)
            report_mismatch("mean_dir_true", got.mean_dir_true, want.mean_dir_true);
        if (got.mean_temperature !== want.mean_temperature)
            report_mismatch("mean_temperature", got.mean_temperature,
                            want.mean_temperature);
        if (got.mean_humidity !== want.mean_humidity)
            report_mismatch("mean_humidity", got.mean_humidity, want.mean_humidity);
        if (got.mean_pressure !== want.mean_pressure)
            report_mismatch("mean_pressure", got.mean_pressure, want.mean_pressure);
    endtask

    // Watch all three channels on each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len = WINDOW_RESET;
            decl = DECLINATION_RESET;
            for (int s = 0; s < NSTA; s++) begin
                win_end[s] = 0;
                clear_station(s);
            end
            window_stats_q.delete();
        end else begin
            if (s_cfg.valid && s_cfg.ready) begin
                if (s_cfg.data.cfg_index == REG_WINDOW_SECONDS)
                    win_len = s_cfg.data.cfg_data[11:0];
                else
                    decl = s_cfg.data.cfg_data;
            end
            if (m_out.valid && m_out.ready) check_result(m_out.data);
            if (s_in.valid && s_in.ready) absorb_sample(s_in.data);
        end
        o_pending <= window_stats_q.size();
        o_failures <= fail_cnt + window_stats_q.size();
    end

    initial begin
        fail_cnt = 0;
        o_pending = 0;
        o_failures = 0;
    end

endmodule

[bench/tb_weather_window_statistics_top.sv]
// Testbench top: clock, reset, sample and register stimulus, and the final verdict.
`timescale 1ns / 1ps
module tb_weather_window_statistics_top;
    import wws_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   failures;
    int   pending;
    bit   quiet_mode;
    int   out_stall;
    logic [31:0] station_clock [2];

    wws_sample_if s_in ();
    wws_cfg_if    s_cfg ();
    wws_result_if m_out ();

    weather_window_statistics_top #(.NUM_STATIONS(2)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in.sink),
        .s_cfg   (s_cfg.sink),
        .m_out   (m_out.source)
    );

    wws_stats_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (s_in),
        .s_cfg      (s_cfg),
        .m_out      (m_out),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_out.ready <= 1'b1;
            out_stall <= 0;
        end else if (out_stall > 0) begin
            m_out.ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            m_out.ready <= 1'b1;
            out_stall <= idle_len();
        end
    end

    // Present one word; valid stays high across back-to-back words.
    task automatic send_sample(input t_sample d);
        int g;
        g = idle_len();
        if (g > 0) begin
            s_in.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data <= d;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // A sample that closes no window may still be in flight.
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        s_cfg.valid <= 1'b1;
        s_cfg.data <= '{cfg_index: idx, cfg_data: val};
        @(posedge i_clk);
        while (!s_cfg.ready) @(posedge i_clk);
        s_cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_sample make_sample(input logic st, input logic [31:0] sec,
                                            input logic [19:0] usec, input logic [4:0] vm);
        t_sample d;
        d.station = st;
        d.time_sec = sec;
        d.time_usec = usec;
        d.valid_mask = vm;
        d.speed = 16'($urandom);
        d.direction = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
        d.temperature = 12'($urandom);
        d.humidity = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1000));
        d.pressure = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 12000));
        return d;
    endfunction

    // Random samples that mostly walk forward through the windows.
    task automatic random_phase(input int n, input int w);
        t_sample d;
        logic st;
        int r;
        logic [19:0] usec;
        for (int k = 0; k < n; k++) begin
            st = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 5)
                station_clock[st] -= $urandom_range(0, w);
            else if (r < 12)
                station_clock[st] += $urandom_range(w, 4 * w + 1);
            else
                station_clock[st] += $urandom_range(0, w / 3 + 1);
            usec = ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(0, 999999));
            d = make_sample(st, station_clock[st], usec,
                            ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'h1F);
            send_sample(d);
        end
        drain_results();
    endtask

    initial begin
        t_sample d;
        i_rst_n = 1'b0;
        quiet_mode = 0;
        s_in.valid = 1'b0;
        s_in.data = '0;
        s_cfg.valid = 1'b0;
        s_cfg.data = '0;
        station_clock[0] = 32'd1000000;
        station_clock[1] = 32'd2000000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first window starts at time zero, edge of the window end.
        d = make_sample(1'b0, 0, 0, 5'h1F);
        d.speed = 16'hFFFF; d.temperature = -12'sd2048; d.humidity = 10'h3FF;
        d.pressure = 14'h3FFF; d.direction = 16'hFFFF;
        send_sample(d);
        d = make_sample(1'b0, 0, 20'd999999, 5'h1F);
        d.speed = 16'h0000; d.temperature = 12'sd2047; d.direction = 16'd0;
        send_sample(d);
        send_sample(make_sample(1'b0, 60, 0, 5'h1F));
        send_sample(make_sample(1'b0, 60, 1, 5'h1F));
        // Time going backwards stays in the current window.
        send_sample(make_sample(1'b0, 10, 5, 5'h1F));
        send_sample(make_sample(1'b0, 0, 0, 5'h00));
        send_sample(make_sample(1'b0, 200, 0, 5'h01));
        send_sample(make_sample(1'b0, 400, 0, 5'h02));
        send_sample(make_sample(1'b0, 600, 0, 5'h04));
        send_sample(make_sample(1'b0, 800, 0, 5'h08));
        send_sample(make_sample(1'b0, 1000, 0, 5'h10));
        send_sample(make_sample(1'b0, 1200, 0, 5'h00));
        // Opposite directions cancel to a zero vector sum.
        d = make_sample(1'b1, 100, 0, 5'h02); d.direction = 16'd0;
        send_sample(d);
        d = make_sample(1'b1, 101, 0, 5'h02); d.direction = 16'd18000;
        send_sample(d);
        d = make_sample(1'b1, 500, 0, 5'h02); d.direction = 16'd27000;
        send_sample(d);
        d = make_sample(1'b1, 900, 0, 5'h1F); d.direction = 16'd36000;
        send_sample(d);
        send_sample(make_sample(1'b1, 1300, 0, 5'h1F));
        drain_results();

        // Random phases over several register settings.
        random_phase(250, 60);
        write_reg(REG_WINDOW_SECONDS, 16'd1);
        write_reg(REG_DECLINATION, 16'd0);
        quiet_mode = 1;
        random_phase(200, 1);
        quiet_mode = 0;
        write_reg(REG_WINDOW_SECONDS, 16'd3600);
        write_reg(REG_DECLINATION, 16'd35999);
        random_phase(200, 3600);
        // Zero window length and a declination above one turn.
        write_reg(REG_WINDOW_SECONDS, 16'd0);
        write_reg(REG_DECLINATION, 16'hFFFF);
        random_phase(150, 1);
        write_reg(REG_WINDOW_SECONDS, 16'hFFFF);
        write_reg(REG_DECLINATION, 16'($urandom_range(0, 35999)));
        random_phase(150, 4095);
        write_reg(REG_WINDOW_SECONDS, 16'($urandom_range(2, 200)));
        write_reg(REG_DECLINATION, 16'($urandom));
        random_phase(200, 100);

        // Window end saturating at the top of the time range.
        write_reg(REG_WINDOW_SECONDS, 16'd3600);
        send_sample(make_sample(1'b0, 32'hFFFF_F000, 0, 5'h1F));
        send_sample(make_sample(1'b0, 32'hFFFF_FFFF, 0, 5'h1F));
        send_sample(make_sample(1'b0, 32'hFFFF_FFFF, 1, 5'h1F));
        send_sample(make_sample(1'b0, 32'hFFFF_FFFF, 7, 5'h1F));
        drain_results();

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wws_pkg.sv
hw/rtl/wws_if.sv
hw/rtl/wws_front.sv
hw/rtl/wws_back.sv
hw/rtl/weather_window_statistics_top.sv
bench/wws_stats_checker.sv
bench/tb_weather_window_statistics_top.sv
